@@ design/dasd_pkg.sv @@
// Shared types, constants and calendar functions for the date shifter.
`default_nettype none
package dasd_pkg;

  localparam int COUNT_BITS_DEF = 16;
  localparam int CNT_W          = 16;
  localparam int YEAR_W         = 14;
  localparam int MONTH_W        = 4;
  localparam int DAY_W          = 5;
  localparam int YMOD_W         = 9;
  localparam int QUOT_W         = 6;
  localparam int IN_TDATA_W     = 40;
  localparam int OUT_TDATA_W    = 24;

  localparam logic [YEAR_W-1:0]  YEAR_MIN  = 14'd1;
  localparam logic [YEAR_W-1:0]  YEAR_MAX  = 14'd9999;
  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

  localparam logic [YMOD_W-1:0] CENT_1   = 9'd100;
  localparam logic [YMOD_W-1:0] CENT_2   = 9'd200;
  localparam logic [YMOD_W-1:0] CENT_3   = 9'd300;
  localparam logic [YMOD_W-1:0] YMOD_TOP = 9'd399;
  localparam logic [YEAR_W-1:0] CYCLE400 = 14'd400;

  localparam int RECIP_W     = 27;
  localparam int RECIP_SHIFT = 21;
  localparam logic [RECIP_W-1:0] RECIP400 = 27'd5243;

  typedef struct packed {
    logic load;
    logic check;
    logic step;
  } cmd_t;

  typedef struct packed {
    logic fin;
  } status_t;

  function automatic logic is_leap(input logic [YMOD_W-1:0] ymod);
    return (ymod[1:0] == 2'b00) && (ymod != CENT_1) && (ymod != CENT_2) && (ymod != CENT_3);
  endfunction

  function automatic logic [DAY_W-1:0] days_in(input logic [MONTH_W-1:0] m, input logic leap);
    logic [DAY_W-1:0] n;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: n = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    n = 5'd30;
      MONTH_FEB:                                  n = leap ? 5'd29 : 5'd28;
      default:                                    n = 5'd0;
    endcase
    return n;
  endfunction

endpackage
`default_nettype wire

@@ design/dasd_ctrl.sv @@
// Controller state machine sequencing load, check and month walk of one request.
`default_nettype none
module dasd_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output dasd_pkg::cmd_t         cmd,
  input  wire dasd_pkg::status_t status
);

  typedef enum logic [1:0] {S_IDLE, S_CHECK, S_WALK, S_OUT} state_t;

  state_t state_r, state_nxt;
  logic   ready_r, ready_nxt;
  logic   valid_r, valid_nxt;

  always_comb begin
    cmd.load  = ready_r && in_tvalid;
    cmd.check = (state_r == S_CHECK);
    cmd.step  = (state_r == S_WALK) && !status.fin;
  end

  always_comb begin
    state_nxt = state_r;
    ready_nxt = ready_r;
    valid_nxt = valid_r;
    case (state_r)
      S_IDLE: begin
        if (ready_r && in_tvalid) begin
          state_nxt = S_CHECK;
          ready_nxt = 1'b0;
        end
      end
      S_CHECK: begin
        state_nxt = S_WALK;
      end
      S_WALK: begin
        if (status.fin) begin
          state_nxt = S_OUT;
          valid_nxt = 1'b1;
        end
      end
      S_OUT: begin
        if (out_tready) begin
          state_nxt = S_IDLE;
          valid_nxt = 1'b0;
          ready_nxt = 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
        ready_nxt = 1'b1;
        valid_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ready_r <= 1'b1;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ready_r <= ready_nxt;
      valid_r <= valid_nxt;
    end
  end

  assign in_tready  = ready_r;
  assign out_tvalid = valid_r;

endmodule
`default_nettype wire

@@ design/dasd_dp.sv @@
// Datapath: request registers, date validation and one-month walk step.
`default_nettype none
module dasd_dp #(
  parameter int COUNT_BITS = dasd_pkg::COUNT_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           in_op,
  input  wire logic [dasd_pkg::YEAR_W-1:0]    in_year,
  input  wire logic [dasd_pkg::MONTH_W-1:0]   in_month,
  input  wire logic [dasd_pkg::DAY_W-1:0]     in_day,
  input  wire logic [dasd_pkg::CNT_W-1:0]     in_count,
  input  wire dasd_pkg::cmd_t                 cmd,
  output dasd_pkg::status_t                   status,
  output logic [dasd_pkg::YEAR_W-1:0]         res_year,
  output logic [dasd_pkg::MONTH_W-1:0]        res_month,
  output logic [dasd_pkg::DAY_W-1:0]          res_day,
  output logic                                res_error
);

  localparam int CW = (COUNT_BITS < dasd_pkg::CNT_W) ? COUNT_BITS : dasd_pkg::CNT_W;
  localparam int DW = ((CW > dasd_pkg::DAY_W) ? CW : dasd_pkg::DAY_W) + 2;

  logic                              op_r;
  logic [dasd_pkg::YEAR_W-1:0]       y0_r, y_r, y_nxt;
  logic [dasd_pkg::MONTH_W-1:0]      m0_r, m_r, m_nxt;
  logic [dasd_pkg::DAY_W-1:0]        d0_r;
  logic [CW-1:0]                     cnt_r;
  logic [dasd_pkg::QUOT_W-1:0]       q_r;
  logic signed [DW-1:0]              d_r, d_nxt;
  logic [dasd_pkg::YMOD_W-1:0]       ymod_r, ymod_nxt;
  logic                              err_r, err_nxt;

  logic [dasd_pkg::RECIP_W-1:0]      prod;
  logic [dasd_pkg::YEAR_W-1:0]       q400, rem;
  logic                              leap0, valid0;
  logic [dasd_pkg::DAY_W-1:0]        dim0, cur_dim, back_dim;
  logic signed [DW-1:0]              d_init, cur_dim_s, back_dim_s;
  logic                              wrap;
  logic [dasd_pkg::MONTH_W-1:0]      m_step;
  logic [dasd_pkg::YEAR_W-1:0]       y_step;
  logic [dasd_pkg::YMOD_W-1:0]       ymod_step;
  logic                              err_step;

  assign prod = dasd_pkg::RECIP_W'(in_year) * dasd_pkg::RECIP400;

  always_comb begin
    q400   = dasd_pkg::YEAR_W'(q_r) * dasd_pkg::CYCLE400;
    rem    = y0_r - q400;
    leap0  = dasd_pkg::is_leap(rem[dasd_pkg::YMOD_W-1:0]);
    dim0   = dasd_pkg::days_in(m0_r, leap0);
    valid0 = (y0_r >= dasd_pkg::YEAR_MIN) && (y0_r <= dasd_pkg::YEAR_MAX) &&
             (m0_r >= dasd_pkg::MONTH_JAN) && (m0_r <= dasd_pkg::MONTH_DEC) &&
             (d0_r != '0) && (d0_r <= dim0);
    if (op_r) begin
      d_init = $signed({{(DW-dasd_pkg::DAY_W){1'b0}}, d0_r}) -
               $signed({{(DW-CW){1'b0}}, cnt_r});
    end else begin
      d_init = $signed({{(DW-dasd_pkg::DAY_W){1'b0}}, d0_r}) +
               $signed({{(DW-CW){1'b0}}, cnt_r});
    end
  end

  always_comb begin
    cur_dim   = dasd_pkg::days_in(m_r, dasd_pkg::is_leap(ymod_r));
    cur_dim_s = $signed({{(DW-dasd_pkg::DAY_W){1'b0}}, cur_dim});
    if (op_r) begin
      wrap      = (m_r == dasd_pkg::MONTH_JAN);
      m_step    = wrap ? dasd_pkg::MONTH_DEC : m_r - 4'd1;
      y_step    = wrap ? y_r - 14'd1 : y_r;
      ymod_step = wrap ? ((ymod_r == '0) ? dasd_pkg::YMOD_TOP : ymod_r - 9'd1) : ymod_r;
      err_step  = wrap && (y_r == dasd_pkg::YEAR_MIN);
    end else begin
      wrap      = (m_r == dasd_pkg::MONTH_DEC);
      m_step    = wrap ? dasd_pkg::MONTH_JAN : m_r + 4'd1;
      y_step    = wrap ? y_r + 14'd1 : y_r;
      ymod_step = wrap ? ((ymod_r == dasd_pkg::YMOD_TOP) ? '0 : ymod_r + 9'd1) : ymod_r;
      err_step  = wrap && (y_r == dasd_pkg::YEAR_MAX);
    end
    back_dim   = dasd_pkg::days_in(m_step, dasd_pkg::is_leap(ymod_step));
    back_dim_s = $signed({{(DW-dasd_pkg::DAY_W){1'b0}}, back_dim});
    if (op_r) begin
      status.fin = err_r || (d_r >= $signed(DW'(1)));
    end else begin
      status.fin = err_r || (d_r <= cur_dim_s);
    end
  end

  always_comb begin
    y_nxt    = y_r;
    m_nxt    = m_r;
    d_nxt    = d_r;
    ymod_nxt = ymod_r;
    err_nxt  = err_r;
    if (cmd.check) begin
      ymod_nxt = rem[dasd_pkg::YMOD_W-1:0];
      d_nxt    = d_init;
      err_nxt  = !valid0;
    end else if (cmd.step) begin
      y_nxt    = y_step;
      m_nxt    = m_step;
      ymod_nxt = ymod_step;
      err_nxt  = err_step;
      d_nxt    = op_r ? d_r + back_dim_s : d_r - cur_dim_s;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= in_op;
      y0_r  <= in_year;
      m0_r  <= in_month;
      d0_r  <= in_day;
      cnt_r <= in_count[CW-1:0];
      q_r   <= prod[dasd_pkg::RECIP_SHIFT +: dasd_pkg::QUOT_W];
      y_r   <= in_year;
      m_r   <= in_month;
    end else begin
      y_r <= y_nxt;
      m_r <= m_nxt;
    end
    d_r    <= d_nxt;
    ymod_r <= ymod_nxt;
    err_r  <= err_nxt;
  end

  assign res_year  = err_r ? y0_r : y_r;
  assign res_month = err_r ? m0_r : m_r;
  assign res_day   = err_r ? d0_r : d_r[dasd_pkg::DAY_W-1:0];
  assign res_error = err_r;

endmodule
`default_nettype wire

@@ design/date_add_subtract_days_core.sv @@
// Top level of the Gregorian date shifter: stream ports, controller and datapath.
// Sequence: the input beat is loaded, the date is checked, then the walk steps one month per cycle
//   until the day fits or an error is found, and the result beat is offered.
// Throughput: one request at a time; the next input beat is taken after the result beat.
// Reset: synchronous active-low rst_n returns the controller to idle, ready for input.
`default_nettype none
module date_add_subtract_days_core #(
  parameter int COUNT_BITS = dasd_pkg::COUNT_BITS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  // start_year[13:0], start_month[17:14], start_day[22:18], day_count[38:23], zero[39]
  input  wire logic [dasd_pkg::IN_TDATA_W-1:0]     in_tdata,
  // op[0]
  input  wire logic                                in_tuser,
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  // result_year[13:0], result_month[17:14], result_day[22:18], zero[23]
  output logic [dasd_pkg::OUT_TDATA_W-1:0]         out_tdata,
  // error[0]
  output logic                                     out_tuser
);

  dasd_pkg::cmd_t                cmd;
  dasd_pkg::status_t             status;
  logic [dasd_pkg::YEAR_W-1:0]   res_year;
  logic [dasd_pkg::MONTH_W-1:0]  res_month;
  logic [dasd_pkg::DAY_W-1:0]    res_day;
  logic                          res_error;

  dasd_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .status     (status)
  );

  dasd_dp #(
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk       (clk),
    .in_op     (in_tuser),
    .in_year   (in_tdata[13:0]),
    .in_month  (in_tdata[17:14]),
    .in_day    (in_tdata[22:18]),
    .in_count  (in_tdata[38:23]),
    .cmd       (cmd),
    .status    (status),
    .res_year  (res_year),
    .res_month (res_month),
    .res_day   (res_day),
    .res_error (res_error)
  );

  assign out_tdata = {1'b0, res_day, res_month, res_year};
  assign out_tuser = res_error;

  a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
    !(out_tvalid && in_tready))
    else $error("input ready while a result beat is pending");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (!in_tready && !out_tvalid))
    else $error("block not busy after taking a request");

  a_result_date_sane: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |->
      (res_day != '0 && res_month >= dasd_pkg::MONTH_JAN && res_month <= dasd_pkg::MONTH_DEC))
    else $error("good result with day zero or bad month");

endmodule
`default_nettype wire
